FILE: rtl/chunk_get_reassembler_macros.svh
// Assertion helpers used by the RTL file cgr_emit.sv
`ifndef CHUNK_GET_REASSEMBLER_MACROS_SVH
`define CHUNK_GET_REASSEMBLER_MACROS_SVH

// Condition that must hold at every edge out of reset
`define CGR_ASSERT_ALWAYS(lbl, c, r, expr) \
  lbl: assert property (@(posedge c) disable iff (r) (expr)) \
    else $error("invariant violated");

// Condition a at one edge implies b at the next edge
`define CGR_ASSERT_NEXT(lbl, c, r, a, b) \
  lbl: assert property (@(posedge c) disable iff (r) (a) |=> (b)) \
    else $error("sequence violated");

`endif

FILE: rtl/cgr_pkg.sv
package cgr_pkg;

  localparam int unsigned MAX_MSG_BYTES_DEF  = 65536;
  localparam int unsigned MAX_XFER_BYTES_DEF = 4096;

  // configuration register indexes
  localparam logic REG_SPDM_VERSION = 1'b0;
  localparam logic REG_CAPACITY     = 1'b1;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BYTE  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_REQ     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // final status codes
  localparam logic [1:0] ST_COMPLETE   = 2'd0;
  localparam logic [1:0] ST_PEER_ERROR = 2'd1;
  localparam logic [1:0] ST_PROTOCOL   = 2'd2;
  localparam logic [1:0] ST_TOO_SMALL  = 2'd3;

  // message codes
  localparam logic [7:0] CODE_GET      = 8'h86;
  localparam logic [7:0] CODE_RESPONSE = 8'h06;
  localparam logic [7:0] CODE_ERROR    = 8'h7F;
  localparam logic [4:0] VER_WIDE_SEQ  = 5'h14;

  // what follows the optional payload byte
  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_REQ  = 2'd1,
    MODE_STAT = 2'd2
  } tail_mode_t;

  // results caused by one accepted item
  typedef struct packed {
    logic       pay;
    logic [7:0] pay_byte;
    logic [15:0] pay_off;
    tail_mode_t mode;
    logic [1:0] st;
    logic [16:0] tot;
    logic [7:0] perr;
  } desc_t;

  // live fields of the outgoing request
  typedef struct packed {
    logic [4:0]  version;
    logic [7:0]  handle;
    logic [31:0] seq;
    logic        wide;
  } req_t;

endpackage

FILE: rtl/cgr_emit.sv
`include "chunk_get_reassembler_macros.svh"

module cgr_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cgr_pkg::desc_t    desc_in,
  input  cgr_pkg::req_t     req,
  output logic              free,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);
  import cgr_pkg::*;

  desc_t      desc;
  logic       valid;
  logic [3:0] cnt;
  logic [3:0] total;
  logic [3:0] rest;
  logic [3:0] j;
  logic [7:0] rbyte;
  logic       take;

  // number of results held by the current descriptor
  always_comb begin
    case (desc.mode)
      MODE_REQ:  rest = req.wide ? 4'd8 : 4'd6;
      MODE_STAT: rest = 4'd1;
      default:   rest = 4'd0;
    endcase
    total = rest + {3'b0, desc.pay};
    j     = cnt - {3'b0, desc.pay};
  end

  // request byte select
  always_comb begin
    case (j[2:0])
      3'd0:    rbyte = {3'b0, req.version};
      3'd1:    rbyte = CODE_GET;
      3'd2:    rbyte = 8'h00;
      3'd3:    rbyte = req.handle;
      3'd4:    rbyte = req.seq[7:0];
      3'd5:    rbyte = req.seq[15:8];
      3'd6:    rbyte = req.seq[23:16];
      default: rbyte = req.seq[31:24];
    endcase
  end

  // output fields: out_byte, offset, status, total_length, peer_error_code
  always_comb begin
    m_tvalid = valid;
    m_tlast  = (cnt == total - 4'd1);
    m_tdata  = '0;
    if (desc.pay && cnt == 4'd0) begin
      m_tuser        = KIND_PAYLOAD;
      m_tdata[7:0]   = desc.pay_byte;
      m_tdata[23:8]  = desc.pay_off;
    end else if (desc.mode == MODE_REQ) begin
      m_tuser        = KIND_REQ;
      m_tdata[7:0]   = rbyte;
      m_tdata[23:8]  = {12'b0, j};
    end else begin
      m_tuser        = KIND_STATUS;
      m_tdata[25:24] = desc.st;
      m_tdata[42:26] = desc.tot;
      m_tdata[50:43] = desc.perr;
    end
  end

  assign take = m_tvalid && m_tready;
  assign free = !valid || (take && m_tlast);

  // descriptor slot and result counter
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      cnt   <= '0;
    end else if (take) begin
      if (m_tlast) begin
        valid <= 1'b0;
        cnt   <= '0;
      end else begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= desc_in;
    end
  end

  `CGR_ASSERT_ALWAYS(a_nonempty, clk, rst, !valid || total != 4'd0)
  `CGR_ASSERT_ALWAYS(a_cnt_range, clk, rst, !valid || cnt < total)
  `CGR_ASSERT_ALWAYS(a_load_free, clk, rst, !load || free)
  `CGR_ASSERT_NEXT(a_drain, clk, rst, take && m_tlast && !load, !valid)

endmodule

FILE: rtl/chunk_get_reassembler.sv
// Chunk retrieval reassembler, requester side.
// Input stream: s_tuser is the command (0 start with handle, 1 received
// byte), s_tdata carries handle and data byte, s_tlast marks a message end.
// Output stream: m_tuser is the result kind (request byte, payload byte,
// final status), m_tlast marks the last result of one input item.
// A start emits the six or eight request bytes for sequence 0. Each
// response byte is parsed the cycle it is accepted; a payload byte comes
// out at its reassembled offset, and the message-end byte adds either the
// next request or one final status.
// The first result of an item comes from a register loaded on its acceptance.
// Results leave one per cycle from the output sequencer while m_tready is
// high, so items with one or no result flow every cycle.
// The input is held off while earlier results still wait beyond the
// current cycle; an output stall holds all results and the input.
// Reset clears the transfer state and loads the default register values.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata are registered.
module chunk_get_reassembler #(
  parameter int unsigned MAX_MSG_BYTES  = cgr_pkg::MAX_MSG_BYTES_DEF,
  parameter int unsigned MAX_XFER_BYTES = cgr_pkg::MAX_XFER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [16:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // handle[7:0], data_byte[15:8]
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,   // msg_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_byte, offset, status, total_length,
                                 // peer_error_code, zero pad
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast    // last
);
  import cgr_pkg::*;

  localparam int CNT_W = $clog2(MAX_XFER_BYTES + 2);

  // configuration
  logic [4:0]  spdm_version;
  logic [16:0] capacity;

  // transfer state
  logic        active, active_next;
  logic [7:0]  saved_handle, saved_handle_next;
  logic [31:0] chunk_seq, chunk_seq_next;
  logic [CNT_W-1:0] msg_byte_count, msg_byte_count_next;
  logic [7:0]  hdr_version, hdr_version_next;
  logic [7:0]  hdr_code, hdr_code_next;
  logic [7:0]  hdr_flags, hdr_flags_next;
  logic [7:0]  hdr_handle, hdr_handle_next;
  logic [31:0] hdr_seq, hdr_seq_next;
  logic [31:0] hdr_chunk_size, hdr_chunk_size_next;
  logic [31:0] expected_total, expected_total_next;
  logic [16:0] filled, filled_next;

  logic        accept, free, load, wide;
  logic [7:0]  b;
  logic [CNT_W-1:0] idx, hl, pos, n;
  logic [31:0] clip_cap, remain, fsum, seq_inc;
  logic        hm, tot_ok;
  desc_t       d;
  req_t        rq;

  assign b      = s_tdata[15:8];
  assign wide   = spdm_version >= VER_WIDE_SEQ;
  assign accept = s_tvalid && s_tready;
  assign s_tready = free;
  assign clip_cap = (32'(capacity) < 32'(MAX_MSG_BYTES)) ? 32'(capacity)
                                                          : 32'(MAX_MSG_BYTES);

  // start handling, per-item parse, payload placement and message-end checks
  always_comb begin
    active_next         = active;
    saved_handle_next   = saved_handle;
    chunk_seq_next      = chunk_seq;
    msg_byte_count_next = msg_byte_count;
    hdr_version_next    = hdr_version;
    hdr_code_next       = hdr_code;
    hdr_flags_next      = hdr_flags;
    hdr_handle_next     = hdr_handle;
    hdr_seq_next        = hdr_seq;
    hdr_chunk_size_next = hdr_chunk_size;
    expected_total_next = expected_total;
    filled_next         = filled;
    load   = 1'b0;
    d      = '0;
    idx    = msg_byte_count;
    hl     = (chunk_seq == 32'd0) ? CNT_W'(16) : CNT_W'(12);
    pos    = idx - hl;
    n      = '0;
    hm     = 1'b0;
    tot_ok = 1'b0;
    remain = '0;
    fsum   = '0;
    seq_inc = chunk_seq + 32'd1;

    if (accept && s_tuser == CMD_START) begin
      active_next         = 1'b1;
      saved_handle_next   = s_tdata[7:0];
      chunk_seq_next      = '0;
      msg_byte_count_next = '0;
      expected_total_next = '0;
      filled_next         = '0;
      load                = 1'b1;
      d.mode              = MODE_REQ;
    end else if (accept && active) begin
      // header capture by byte position
      case (idx)
        CNT_W'(0): begin
          hdr_version_next    = b;
          hdr_code_next       = '0;
          hdr_flags_next      = '0;
          hdr_handle_next     = '0;
          hdr_seq_next        = '0;
          hdr_chunk_size_next = '0;
        end
        CNT_W'(1):  hdr_code_next = b;
        CNT_W'(2):  hdr_flags_next = b;
        CNT_W'(3):  hdr_handle_next = b;
        CNT_W'(4):  hdr_seq_next = {24'b0, b};
        CNT_W'(5):  hdr_seq_next[15:8] = b;
        CNT_W'(6):  if (wide) hdr_seq_next[23:16] = b;
        CNT_W'(7):  if (wide) hdr_seq_next[31:24] = b;
        CNT_W'(8):  hdr_chunk_size_next = {24'b0, b};
        CNT_W'(9):  hdr_chunk_size_next[15:8] = b;
        CNT_W'(10): hdr_chunk_size_next[23:16] = b;
        CNT_W'(11): hdr_chunk_size_next[31:24] = b;
        CNT_W'(12): if (chunk_seq == 32'd0) expected_total_next = {24'b0, b};
        CNT_W'(13): if (chunk_seq == 32'd0) expected_total_next[15:8] = b;
        CNT_W'(14): if (chunk_seq == 32'd0) expected_total_next[23:16] = b;
        CNT_W'(15): if (chunk_seq == 32'd0) expected_total_next[31:24] = b;
        default: ;
      endcase

      hm = hdr_version_next == {3'b0, spdm_version} &&
           hdr_code_next == CODE_RESPONSE &&
           hdr_handle_next == saved_handle &&
           (wide ? hdr_seq_next : {16'b0, hdr_seq_next[15:0]}) == chunk_seq;
      tot_ok = expected_total_next != 32'd0 && expected_total_next <= clip_cap &&
               {15'b0, filled} <= expected_total_next;
      remain = expected_total_next - {15'b0, filled};

      // payload byte
      if (idx >= hl && 32'(idx) < 32'(MAX_XFER_BYTES) && hm && tot_ok &&
          32'(pos) < hdr_chunk_size_next && 32'(pos) < remain) begin
        d.pay      = 1'b1;
        d.pay_byte = b;
        d.pay_off  = filled[15:0] + 16'(pos);
      end

      if (32'(idx) <= 32'(MAX_XFER_BYTES)) begin
        msg_byte_count_next = idx + CNT_W'(1);
      end

      // message end
      if (s_tlast) begin
        n = msg_byte_count_next;
        msg_byte_count_next = '0;
        fsum = {15'b0, filled} + hdr_chunk_size_next;
        d.mode = MODE_STAT;
        d.st   = ST_PROTOCOL;
        if (32'(n) > 32'(MAX_XFER_BYTES)) begin
          d.st = ST_PROTOCOL;
        end else if (n >= CNT_W'(4) && hdr_code_next == CODE_ERROR) begin
          d.st   = ST_PEER_ERROR;
          d.perr = hdr_flags_next;
        end else if (n < hl || !hm) begin
          d.st = ST_PROTOCOL;
        end else if (chunk_seq == 32'd0 && expected_total_next == 32'd0) begin
          d.st = ST_PROTOCOL;
        end else if (chunk_seq == 32'd0 && expected_total_next > clip_cap) begin
          d.st = ST_TOO_SMALL;
        end else if ({15'b0, filled} > expected_total_next ||
                     hdr_chunk_size_next == 32'd0 ||
                     hdr_chunk_size_next != 32'(n - hl) ||
                     hdr_chunk_size_next > remain) begin
          d.st = ST_PROTOCOL;
        end else begin
          filled_next = fsum[16:0];
          if (hdr_flags_next[0] != (fsum == expected_total_next)) begin
            d.st = ST_PROTOCOL;
          end else if (hdr_flags_next[0]) begin
            d.st  = ST_COMPLETE;
            d.tot = expected_total_next[16:0];
          end else begin
            chunk_seq_next = seq_inc;
            if (!wide && seq_inc > 32'h0000_FFFF) begin
              d.st = ST_PROTOCOL;
            end else begin
              d.mode = MODE_REQ;
              d.st   = ST_COMPLETE;
            end
          end
        end
        if (d.mode == MODE_STAT) begin
          active_next = 1'b0;
        end
      end
      load = d.pay || s_tlast;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spdm_version <= 5'd18;
      capacity     <= 17'h10000;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SPDM_VERSION: spdm_version <= cfg_wdata[4:0];
        REG_CAPACITY:     capacity <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      saved_handle   <= '0;
      chunk_seq      <= '0;
      msg_byte_count <= '0;
      hdr_version    <= '0;
      hdr_code       <= '0;
      hdr_flags      <= '0;
      hdr_handle     <= '0;
      hdr_seq        <= '0;
      hdr_chunk_size <= '0;
      expected_total <= '0;
      filled         <= '0;
    end else begin
      active         <= active_next;
      saved_handle   <= saved_handle_next;
      chunk_seq      <= chunk_seq_next;
      msg_byte_count <= msg_byte_count_next;
      hdr_version    <= hdr_version_next;
      hdr_code       <= hdr_code_next;
      hdr_flags      <= hdr_flags_next;
      hdr_handle     <= hdr_handle_next;
      hdr_seq        <= hdr_seq_next;
      hdr_chunk_size <= hdr_chunk_size_next;
      expected_total <= expected_total_next;
      filled         <= filled_next;
    end
  end

  // request fields read live while results drain
  always_comb begin
    rq.version = spdm_version;
    rq.handle  = saved_handle;
    rq.seq     = chunk_seq;
    rq.wide    = wide;
  end

  cgr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .desc_in  (d),
    .req      (rq),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
